/* hdl/cgab_pkg.sv */
`timescale 1ns / 1ps

package cgab_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_LEFT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_TOP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_RIGHT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_BOTTOM = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOR  = 3'd7;

    localparam logic [14:0] PITCH_RESET  = 15'd1;
    localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
    localparam logic [16:0] ROUND_BIAS   = 17'd128;

    typedef struct packed {
        logic signed [15:0] glyph_left;
        logic signed [15:0] glyph_top;
        logic [14:0]        clip_left;
        logic [14:0]        clip_top;
        logic [14:0]        clip_right;
        logic [14:0]        clip_bottom;
        logic [14:0]        row_pitch;
        logic [23:0]        text_color;
    } cfg_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } stage_en_t;

endpackage

/* hdl/cgab_cfg.sv */
`timescale 1ns / 1ps

module cgab_cfg
    import cgab_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_GLYPH_LEFT:  cfg_next.glyph_left  = cfg_data[15:0];
                REG_GLYPH_TOP:   cfg_next.glyph_top   = cfg_data[15:0];
                REG_CLIP_LEFT:   cfg_next.clip_left   = cfg_data[14:0];
                REG_CLIP_TOP:    cfg_next.clip_top    = cfg_data[14:0];
                REG_CLIP_RIGHT:  cfg_next.clip_right  = cfg_data[14:0];
                REG_CLIP_BOTTOM: cfg_next.clip_bottom = cfg_data[14:0];
                REG_ROW_PITCH:   cfg_next.row_pitch   = cfg_data[14:0];
                REG_TEXT_COLOR:  cfg_next.text_color  = cfg_data[23:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.glyph_left  <= '0;
            cfg_reg.glyph_top   <= '0;
            cfg_reg.clip_left   <= '0;
            cfg_reg.clip_top    <= '0;
            cfg_reg.clip_right  <= '0;
            cfg_reg.clip_bottom <= '0;
            cfg_reg.row_pitch   <= PITCH_RESET;
            cfg_reg.text_color  <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hdl/cgab_locate.sv */
`timescale 1ns / 1ps

module cgab_locate
    import cgab_pkg::*;
#(
    parameter int MAX_GLYPH_DIM = 1024
)
(
    input  logic        clk,
    input  stage_en_t   en,
    input  cfg_t        cfg,
    input  logic [9:0]  glyph_col,
    input  logic [9:0]  glyph_row,
    input  logic        we_s2,
    output logic        inside_s2,
    output logic [29:0] pixel_index
);

    localparam logic [12:0] GLYPH_LIM = 13'(MAX_GLYPH_DIM);

    logic signed [16:0] dx_reg;
    logic signed [16:0] dy_reg;
    logic               in_glyph_reg;
    logic signed [16:0] dx_next;
    logic signed [16:0] dy_next;
    logic               in_glyph_next;

    logic               inside_reg;
    logic               inside_next;
    logic [29:0]        prod_reg;
    logic [29:0]        prod_next;
    logic [14:0]        dx_lo_reg;

    logic [29:0]        index_reg;
    logic [29:0]        index_next;
    logic [30:0]        index_sum;

    always_comb
    begin
        dx_next = {cfg.glyph_left[15], cfg.glyph_left} + $signed({7'd0, glyph_col});
        dy_next = {cfg.glyph_top[15], cfg.glyph_top} + $signed({7'd0, glyph_row});
        in_glyph_next = ({3'b000, glyph_col} < GLYPH_LIM) && ({3'b000, glyph_row} < GLYPH_LIM);
    end

    always_comb
    begin
        inside_next = in_glyph_reg
            && (dx_reg >= $signed({2'b00, cfg.clip_left}))
            && (dx_reg <  $signed({2'b00, cfg.clip_right}))
            && (dy_reg >= $signed({2'b00, cfg.clip_top}))
            && (dy_reg <  $signed({2'b00, cfg.clip_bottom}));
        prod_next = 30'(dy_reg[14:0]) * 30'(cfg.row_pitch);
    end

    always_comb
    begin
        index_sum  = {1'b0, prod_reg} + {16'd0, dx_lo_reg};
        index_next = we_s2 ? index_sum[29:0] : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            dx_reg       <= dx_next;
            dy_reg       <= dy_next;
            in_glyph_reg <= in_glyph_next;
        end
        if (en.s2)
        begin
            inside_reg <= inside_next;
            prod_reg   <= prod_next;
            dx_lo_reg  <= dx_reg[14:0];
        end
        if (en.s3)
        begin
            index_reg <= index_next;
        end
    end

    assign inside_s2   = inside_reg;
    assign pixel_index = index_reg;

endmodule

/* hdl/cgab_blend.sv */
`timescale 1ns / 1ps

module cgab_blend
    import cgab_pkg::*;
(
    input  logic        clk,
    input  stage_en_t   en,
    input  cfg_t        cfg,
    input  logic        kind,
    input  logic [31:0] background_pixel,
    input  logic [31:0] source_color,
    input  logic [7:0]  coverage,
    input  logic        we_s2,
    output logic        clear_s2,
    output logic [31:0] blended_pixel
);

    logic        kind_reg;
    logic [31:0] bg1_reg;
    logic [31:0] src1_reg;
    logic [7:0]  cov_reg;

    logic [7:0]  alpha;
    logic [7:0]  weight;
    logic [7:0]  inv;
    logic [2:0][7:0]  fg;
    logic [2:0][15:0] pfg_next;
    logic [2:0][15:0] pbg_next;

    logic [2:0][15:0] pfg_reg;
    logic [2:0][15:0] pbg_reg;
    logic        clear_reg;
    logic        opaque_reg;
    logic [31:0] bg2_reg;
    logic [23:0] src_rgb_reg;

    logic [2:0][16:0] sum;
    logic [2:0][7:0]  mix;
    logic [31:0] pixel_next;
    logic [31:0] pixel_reg;

    always_comb
    begin
        alpha  = kind_reg ? src1_reg[31:24] : cov_reg;
        weight = kind_reg ? ALPHA_OPAQUE : cov_reg;
        inv    = ALPHA_OPAQUE - alpha;
        for (int c = 0; c < 3; c++)
        begin
            fg[c]       = kind_reg ? src1_reg[8*c +: 8] : cfg.text_color[8*c +: 8];
            pfg_next[c] = 16'(fg[c]) * 16'(weight);
            pbg_next[c] = 16'(bg1_reg[8*c +: 8]) * 16'(inv);
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            sum[c] = {1'b0, pfg_reg[c]} + {1'b0, pbg_reg[c]} + ROUND_BIAS;
            mix[c] = sum[c][15:8];
        end
        if (!we_s2)
        begin
            pixel_next = bg2_reg;
        end
        else if (opaque_reg)
        begin
            pixel_next = {bg2_reg[31:24], src_rgb_reg};
        end
        else
        begin
            pixel_next = {bg2_reg[31:24], mix[2], mix[1], mix[0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            kind_reg <= kind;
            bg1_reg  <= background_pixel;
            src1_reg <= source_color;
            cov_reg  <= coverage;
        end
        if (en.s2)
        begin
            pfg_reg     <= pfg_next;
            pbg_reg     <= pbg_next;
            clear_reg   <= (alpha == 8'd0);
            opaque_reg  <= kind_reg && (alpha == ALPHA_OPAQUE);
            bg2_reg     <= bg1_reg;
            src_rgb_reg <= src1_reg[23:0];
        end
        if (en.s3)
        begin
            pixel_reg <= pixel_next;
        end
    end

    assign clear_s2      = clear_reg;
    assign blended_pixel = pixel_reg;

endmodule

/* hdl/clipped_glyph_alpha_blender.sv */
`timescale 1ns / 1ps

// Channel   Handshake            Payload
// input     in_valid/in_stall    kind, glyph_col, glyph_row, background_pixel,
//                                source_color, coverage
// output    out_valid/out_stall  write_enable, pixel_index, blended_pixel
// config    cfg_we               cfg_index, cfg_data
//
// One transfer per cycle in and out while in_stall and out_stall are low; a result is
// presented once its input has passed three register stages: origin add, clip test with the
// six channel products and the row multiplier, then the rounding adds and index add into the
// output register.
// Reset clears the stage valid bits and loads the register defaults (row_pitch 1).
// Each stage loads when empty or when the next one moves; in_stall rises only when all
// three stages are full and out_stall is high.

module clipped_glyph_alpha_blender
    import cgab_pkg::*;
#(
    parameter int MAX_GLYPH_DIM = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  kind,
    input  logic [9:0]            glyph_col,
    input  logic [9:0]            glyph_row,
    input  logic [31:0]           background_pixel,
    input  logic [31:0]           source_color,
    input  logic [7:0]            coverage,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  write_enable,
    output logic [29:0]           pixel_index,
    output logic [31:0]           blended_pixel,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t      cfg;
    stage_en_t en;

    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic v1_next;
    logic v2_next;
    logic v3_next;

    logic inside_s2;
    logic clear_s2;
    logic we_s2;
    logic we_reg;

    always_comb
    begin
        en.s3   = !v3_reg || !out_stall;
        en.s2   = !v2_reg || en.s3;
        en.s1   = !v1_reg || en.s2;
        v1_next = en.s1 ? in_valid : v1_reg;
        v2_next = en.s2 ? v1_reg : v2_reg;
        v3_next = en.s3 ? v2_reg : v3_reg;
        we_s2   = inside_s2 && !clear_s2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            we_reg <= we_s2;
        end
    end

    cgab_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cgab_locate #(
        .MAX_GLYPH_DIM (MAX_GLYPH_DIM)
    ) u_locate (
        .clk         (clk),
        .en          (en),
        .cfg         (cfg),
        .glyph_col   (glyph_col),
        .glyph_row   (glyph_row),
        .we_s2       (we_s2),
        .inside_s2   (inside_s2),
        .pixel_index (pixel_index)
    );

    cgab_blend u_blend (
        .clk              (clk),
        .en               (en),
        .cfg              (cfg),
        .kind             (kind),
        .background_pixel (background_pixel),
        .source_color     (source_color),
        .coverage         (coverage),
        .we_s2            (we_s2),
        .clear_s2         (clear_s2),
        .blended_pixel    (blended_pixel)
    );

    assign in_stall     = !en.s1;
    assign out_valid    = v3_reg;
    assign write_enable = we_reg;

endmodule

/* tb/sv/pixel_blend_checker.sv */
`timescale 1ns / 1ps

module pixel_blend_checker
    import cgab_pkg::*;
#(
    parameter int GLYPH_DIM = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic                  kind,
    input  logic [9:0]            glyph_col,
    input  logic [9:0]            glyph_row,
    input  logic [31:0]           background_pixel,
    input  logic [31:0]           source_color,
    input  logic [7:0]            coverage,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic                  write_enable,
    input  logic [29:0]           pixel_index,
    input  logic [31:0]           blended_pixel,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatch_count,
    output int                    pending_count
);

    typedef struct packed {
        logic        we;
        logic [29:0] index;
        logic [31:0] pixel;
    } pixel_write_t;

    localparam cfg_t REGS_AT_RESET = '{
        glyph_left:  '0,
        glyph_top:   '0,
        clip_left:   '0,
        clip_top:    '0,
        clip_right:  '0,
        clip_bottom: '0,
        row_pitch:   PITCH_RESET,
        text_color:  '0
    };

    cfg_t         regs;
    pixel_write_t expected_writes[$];
    pixel_write_t oldest;

    function automatic logic [7:0] mix_channel(int unsigned term, logic [7:0] bg_ch,
                                               logic [7:0] inv);
        logic [31:0] sum;
        sum = term + int'(bg_ch) * int'(inv) + 128;
        return sum[15:8];
    endfunction

    function automatic pixel_write_t blend_pixel(cfg_t r, logic k, logic [9:0] col,
                                                 logic [9:0] row, logic [31:0] bg,
                                                 logic [31:0] src, logic [7:0] cov);
        int                dx;
        int                dy;
        logic [7:0]        alpha;
        logic [7:0]        inv;
        logic [23:0]       color;
        longint unsigned   full;
        pixel_write_t      res;
        dx = int'(r.glyph_left) + int'(col);
        dy = int'(r.glyph_top) + int'(row);
        res.we = (int'(col) < GLYPH_DIM) && (int'(row) < GLYPH_DIM) &&
                 (dx >= int'(r.clip_left)) && (dx < int'(r.clip_right)) &&
                 (dy >= int'(r.clip_top)) && (dy < int'(r.clip_bottom));
        res.index = '0;
        res.pixel = bg;
        alpha = k ? src[31:24] : cov;
        color = k ? src[23:0] : r.text_color;
        if (res.we && alpha == 8'h00) begin
            res.we = 1'b0;
        end
        if (res.we) begin
            inv = 8'd255 - alpha;
            if (k && alpha == ALPHA_OPAQUE) begin
                res.pixel = {bg[31:24], src[23:0]};
            end
            else begin
                res.pixel[23:16] = mix_channel(int'(color[23:16]) * (k ? 255 : int'(cov)),
                                               bg[23:16], inv);
                res.pixel[15:8]  = mix_channel(int'(color[15:8]) * (k ? 255 : int'(cov)),
                                               bg[15:8], inv);
                res.pixel[7:0]   = mix_channel(int'(color[7:0]) * (k ? 255 : int'(cov)),
                                               bg[7:0], inv);
            end
            full = longint'(dy) * longint'(r.row_pitch) + longint'(dx);
            res.index = full[29:0];
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs <= REGS_AT_RESET;
            expected_writes.delete();
            pending_count <= 0;
            mismatch_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_GLYPH_LEFT:  regs.glyph_left  <= cfg_data[15:0];
                    REG_GLYPH_TOP:   regs.glyph_top   <= cfg_data[15:0];
                    REG_CLIP_LEFT:   regs.clip_left   <= cfg_data[14:0];
                    REG_CLIP_TOP:    regs.clip_top    <= cfg_data[14:0];
                    REG_CLIP_RIGHT:  regs.clip_right  <= cfg_data[14:0];
                    REG_CLIP_BOTTOM: regs.clip_bottom <= cfg_data[14:0];
                    REG_ROW_PITCH:   regs.row_pitch   <= cfg_data[14:0];
                    REG_TEXT_COLOR:  regs.text_color  <= cfg_data[23:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (expected_writes.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected transfer, expected none, actual we %0b index %0h pixel %08h",
                             $time, write_enable, pixel_index, blended_pixel);
                end
                else
                begin
                    oldest = expected_writes.pop_front();
                    if (write_enable !== oldest.we)
                    begin
                        mismatch_count++;
                        $display("%0t: write_enable expected %0b actual %0b",
                                 $time, oldest.we, write_enable);
                    end
                    if (pixel_index !== oldest.index)
                    begin
                        mismatch_count++;
                        $display("%0t: pixel_index expected %0h actual %0h",
                                 $time, oldest.index, pixel_index);
                    end
                    if (blended_pixel !== oldest.pixel)
                    begin
                        mismatch_count++;
                        $display("%0t: blended_pixel expected %08h actual %08h",
                                 $time, oldest.pixel, blended_pixel);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                expected_writes.insert(expected_writes.size(),
                                       blend_pixel(regs, kind, glyph_col, glyph_row,
                                                   background_pixel, source_color,
                                                   coverage));
            end
            pending_count <= expected_writes.size();
        end
    end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import cgab_pkg::*;

    localparam int LIMIT_CYCLES    = 200000;
    localparam int LONG_HOLD       = 300;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 100;

    typedef struct packed {
        logic        k;
        logic [9:0]  col;
        logic [9:0]  row;
        logic [31:0] bg;
        logic [31:0] src;
        logic [7:0]  cov;
    } glyph_pixel_t;

    logic                  clk              = 1'b0;
    logic                  rst_n            = 1'b0;
    logic                  in_valid         = 1'b0;
    logic                  in_stall;
    logic                  kind             = 1'b0;
    logic [9:0]            glyph_col        = '0;
    logic [9:0]            glyph_row        = '0;
    logic [31:0]           background_pixel = '0;
    logic [31:0]           source_color     = '0;
    logic [7:0]            coverage         = '0;
    logic                  out_valid;
    logic                  out_stall        = 1'b0;
    logic                  write_enable;
    logic [29:0]           pixel_index;
    logic [31:0]           blended_pixel;
    logic                  cfg_we           = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index        = REG_GLYPH_LEFT;
    logic [CFG_DATA_W-1:0] cfg_data         = '0;

    int mismatch_count;
    int pending_count;
    int cycle_count  = 0;
    bit sender_eager = 1'b0;
    bit sink_eager   = 1'b0;
    bit hold_request = 1'b0;

    always #5 clk = ~clk;

    clipped_glyph_alpha_blender DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .kind             (kind),
        .glyph_col        (glyph_col),
        .glyph_row        (glyph_row),
        .background_pixel (background_pixel),
        .source_color     (source_color),
        .coverage         (coverage),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .write_enable     (write_enable),
        .pixel_index      (pixel_index),
        .blended_pixel    (blended_pixel),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    pixel_blend_checker blend_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .kind             (kind),
        .glyph_col        (glyph_col),
        .glyph_row        (glyph_row),
        .background_pixel (background_pixel),
        .source_color     (source_color),
        .coverage         (coverage),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .write_enable     (write_enable),
        .pixel_index      (pixel_index),
        .blended_pixel    (blended_pixel),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mismatch_count   (mismatch_count),
        .pending_count    (pending_count)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // hold out_stall for a drawn number of cycles, then take one transfer
    initial
    begin
        int hold;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                hold = LONG_HOLD;
                hold_request = 1'b0;
            end
            else
            begin
                hold = sink_eager ? 0 : $urandom_range(0, 17);
            end
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    function automatic glyph_pixel_t make_pixel(logic k, int col, int row, logic [31:0] bg,
                                                logic [31:0] src, logic [7:0] cov);
        glyph_pixel_t p;
        p.k   = k;
        p.col = col[9:0];
        p.row = row[9:0];
        p.bg  = bg;
        p.src = src;
        p.cov = cov;
        return p;
    endfunction

    function automatic logic [7:0] random_alpha();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic glyph_pixel_t random_pixel();
        glyph_pixel_t p;
        p.k   = 1'($urandom_range(0, 1));
        p.col = 10'($urandom_range(0, 1023));
        p.row = 10'($urandom_range(0, 1023));
        p.bg  = $urandom;
        p.src = {random_alpha(), 24'($urandom)};
        p.cov = random_alpha();
        return p;
    endfunction

    function automatic cfg_t random_config();
        cfg_t c;
        c.clip_left   = 15'($urandom_range(0, 3000));
        c.clip_top    = 15'($urandom_range(0, 3000));
        c.clip_right  = 15'(int'(c.clip_left) + int'($urandom_range(1, 1024)));
        c.clip_bottom = 15'(int'(c.clip_top) + int'($urandom_range(1, 1024)));
        c.glyph_left  = 16'(int'(c.clip_left) - int'($urandom_range(0, 100)));
        c.glyph_top   = 16'(int'(c.clip_top) - int'($urandom_range(0, 100)));
        c.row_pitch   = 15'($urandom_range(1, 8192));
        c.text_color  = 24'($urandom);
        return c;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic program_regs(cfg_t c);
        write_reg(REG_GLYPH_LEFT,  {8'h00, c.glyph_left});
        write_reg(REG_GLYPH_TOP,   {8'h00, c.glyph_top});
        write_reg(REG_CLIP_LEFT,   {9'h000, c.clip_left});
        write_reg(REG_CLIP_TOP,    {9'h000, c.clip_top});
        write_reg(REG_CLIP_RIGHT,  {9'h000, c.clip_right});
        write_reg(REG_CLIP_BOTTOM, {9'h000, c.clip_bottom});
        write_reg(REG_ROW_PITCH,   {9'h000, c.row_pitch});
        write_reg(REG_TEXT_COLOR,  c.text_color);
        cfg_we <= 1'b0;
    endtask

    task automatic send_pixel(glyph_pixel_t p);
        int gap;
        gap = sender_eager ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid         <= 1'b1;
        kind             <= p.k;
        glyph_col        <= p.col;
        glyph_row        <= p.row;
        background_pixel <= p.bg;
        source_color     <= p.src;
        coverage         <= p.cov;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_count != 0);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        cfg_t c;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // registers at reset: empty clip
        send_pixel(make_pixel(1'b0, 0, 0, 32'h0000_0000, 32'h0000_0000, 8'hFF));
        send_pixel(make_pixel(1'b1, 1023, 1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00));
        drain();

        c = '{glyph_left: -16'sd20, glyph_top: -16'sd4, clip_left: 15'd0, clip_top: 15'd0,
              clip_right: 15'd1000, clip_bottom: 15'd1000, row_pitch: 15'd1000,
              text_color: 24'hFF8040};
        program_regs(c);
        send_pixel(make_pixel(1'b0, 20, 4, 32'h0000_0000, 32'h0, 8'hFF));
        send_pixel(make_pixel(1'b0, 100, 100, 32'h1234_5678, 32'h0, 8'h00));
        send_pixel(make_pixel(1'b0, 1019, 1003, 32'hFFFF_FFFF, 32'h0, 8'h80));
        send_pixel(make_pixel(1'b1, 200, 300, 32'h8899_AABB, 32'h00FF_FFFF, 8'hFF));
        send_pixel(make_pixel(1'b1, 201, 300, 32'h0000_0000, 32'hFFFF_FFFF, 8'h00));
        send_pixel(make_pixel(1'b1, 202, 300, 32'h1234_5678, 32'h8040_2010, 8'h00));
        send_pixel(make_pixel(1'b1, 203, 300, 32'hFFFF_FFFF, 32'h01FF_FFFF, 8'h00));
        send_pixel(make_pixel(1'b1, 204, 300, 32'h00FF_00FF, 32'hFE10_2030, 8'h00));
        send_pixel(make_pixel(1'b0, 19, 500, 32'hAAAA_AAAA, 32'h0, 8'hFF));
        send_pixel(make_pixel(1'b0, 500, 3, 32'hAAAA_AAAA, 32'h0, 8'hFF));
        send_pixel(make_pixel(1'b1, 1020, 500, 32'h5555_5555, 32'hFFFF_FFFF, 8'hFF));
        send_pixel(make_pixel(1'b1, 500, 1004, 32'h5555_5555, 32'hFFFF_FFFF, 8'hFF));
        send_pixel(make_pixel(1'b0, 1023, 1023, 32'h5555_5555, 32'h0, 8'hFF));
        send_pixel(make_pixel(1'b0, 0, 0, 32'h5555_5555, 32'h0, 8'hFF));
        send_pixel(make_pixel(1'b0, 500, 500, 32'hAA55_AA55, 32'h0, 8'h01));
        drain();

        c = '{glyph_left: 16'sd32767, glyph_top: -16'sd32768, clip_left: 15'd0,
              clip_top: 15'd0, clip_right: 15'd32767, clip_bottom: 15'd32767,
              row_pitch: 15'd32767, text_color: 24'hFFFFFF};
        program_regs(c);
        send_pixel(make_pixel(1'b0, 0, 1023, 32'h0102_0304, 32'h0, 8'hFF));
        send_pixel(make_pixel(1'b1, 1023, 1023, 32'h0102_0304, 32'hFFFF_FFFF, 8'h00));
        drain();

        c = '{glyph_left: 16'sd31744, glyph_top: 16'sd31744, clip_left: 15'd31744,
              clip_top: 15'd31744, clip_right: 15'd32767, clip_bottom: 15'd32767,
              row_pitch: 15'd32767, text_color: 24'hFFFFFF};
        program_regs(c);
        send_pixel(make_pixel(1'b0, 1022, 1022, 32'h0000_0000, 32'h0, 8'h7F));
        send_pixel(make_pixel(1'b1, 1023, 1022, 32'h0000_0000, 32'hFF12_3456, 8'h00));
        send_pixel(make_pixel(1'b1, 0, 0, 32'hC0C0_C0C0, 32'hFF12_3456, 8'h00));
        drain();

        // zero pitch: index is x alone
        c = '{glyph_left: 16'sd0, glyph_top: 16'sd0, clip_left: 15'd0, clip_top: 15'd0,
              clip_right: 15'd500, clip_bottom: 15'd500, row_pitch: 15'd0,
              text_color: 24'h000000};
        program_regs(c);
        send_pixel(make_pixel(1'b0, 7, 9, 32'h7F7F_7F7F, 32'h0, 8'hC0));
        send_pixel(make_pixel(1'b1, 499, 499, 32'h7F7F_7F7F, 32'h8080_8080, 8'h00));
        drain();

        c = '{glyph_left: -16'sd32768, glyph_top: 16'sd32767, clip_left: 15'd600,
              clip_top: 15'd0, clip_right: 15'd100, clip_bottom: 15'd32767,
              row_pitch: 15'd640, text_color: 24'h123456};
        program_regs(c);
        send_pixel(make_pixel(1'b0, 300, 10, 32'hDEAD_BEEF, 32'h0, 8'hFF));
        drain();

        c.glyph_left = 16'sd0;
        c.glyph_top  = 16'sd0;
        c.clip_left  = 15'd100;
        c.clip_top   = 15'd50;
        c.clip_bottom = 15'd50;
        program_regs(c);
        send_pixel(make_pixel(1'b1, 100, 50, 32'hDEAD_BEEF, 32'hFFFF_FFFF, 8'h00));
        drain();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            program_regs(random_config());
            sender_eager = (phase % 3) != 0;
            sink_eager   = (phase % 3) == 1;
            if (phase == 3)
            begin
                hold_request = 1'b1;
            end
            repeat (ITEMS_PER_PHASE) send_pixel(random_pixel());
            drain();
        end

        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/cgab_pkg.sv
hdl/cgab_cfg.sv
hdl/cgab_locate.sv
hdl/cgab_blend.sv
hdl/clipped_glyph_alpha_blender.sv
tb/sv/pixel_blend_checker.sv
tb/sv/testbench.sv
